[rtl/core/brmc_pkg.sv]
// Shared constants, types and helpers of the burst region mode controller.
`default_nettype none

package brmc_pkg;

  // Default widths of the sample and frequency fields.
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned FREQ_BITS_DEF   = 20;

  // Widths fixed by the counters and the port.
  localparam int unsigned CNT_BITS      = 16;
  localparam int unsigned TICK_BITS     = 32;
  localparam int unsigned REGION_BITS   = 3;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Register reset values.
  localparam int unsigned VREF_RESET       = 1236;
  localparam int unsigned FREQ_CEIL_RESET  = 170000;
  localparam int unsigned ENTRY_HYST_RESET = 25;
  localparam int unsigned EXIT_HYST_RESET  = 25;
  localparam int unsigned PERSIST_RESET    = 25;
  localparam int unsigned DWELL_RESET      = 2500;
  localparam int unsigned RETURN_RESET     = 500;
  localparam int unsigned PACKET_RESET     = 1;

  // Region codes as reported on the result channel.
  localparam logic [REGION_BITS-1:0] REGION_IDLE  = 3'd0;
  localparam logic [REGION_BITS-1:0] REGION_RUN   = 3'd1;
  localparam logic [REGION_BITS-1:0] REGION_PREP  = 3'd2;
  localparam logic [REGION_BITS-1:0] REGION_ON    = 3'd3;
  localparam logic [REGION_BITS-1:0] REGION_OFF   = 3'd4;
  localparam logic [REGION_BITS-1:0] REGION_FAULT = 3'd5;

  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_RUN   = 6'b000010,
    MODE_PREP  = 6'b000100,
    MODE_ON    = 6'b001000,
    MODE_OFF   = 6'b010000,
    MODE_FAULT = 6'b100000
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_VREF       = 3'd0,
    CFG_FREQ_CEIL  = 3'd1,
    CFG_ENTRY_HYST = 3'd2,
    CFG_EXIT_HYST  = 3'd3,
    CFG_PERSIST    = 3'd4,
    CFG_DWELL      = 3'd5,
    CFG_RETURN     = 3'd6,
    CFG_PACKET     = 3'd7
  } cfg_idx_e;

  // Control bits of one tick handed to the state machine.
  typedef struct packed {
    logic fire;
    logic rising;
    logic enable;
    logic fault;
    logic handoff;
  } brmc_step_t;

  function automatic logic [REGION_BITS-1:0] region_code(mode_e mode);
    logic [REGION_BITS-1:0] code;
    unique case (mode)
      MODE_IDLE:  code = REGION_IDLE;
      MODE_RUN:   code = REGION_RUN;
      MODE_PREP:  code = REGION_PREP;
      MODE_ON:    code = REGION_ON;
      MODE_OFF:   code = REGION_OFF;
      MODE_FAULT: code = REGION_FAULT;
      default:    code = REGION_FAULT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[rtl/core/brmc_if.sv]
// Request, result and configuration channel interfaces of the controller.
`default_nettype none

interface brmc_in_if #(
  parameter int unsigned SAMPLE_BITS = brmc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FREQ_BITS   = brmc_pkg::FREQ_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] vout_sample;
  logic                   vout_rising;
  logic [FREQ_BITS-1:0]   freq_command;
  logic                   run_enable;
  logic                   fault_active;
  logic                   handoff_pulse;

  modport source (
    output valid, vout_sample, vout_rising, freq_command, run_enable, fault_active,
           handoff_pulse,
    input  ready
  );
  modport sink (
    input  valid, vout_sample, vout_rising, freq_command, run_enable, fault_active,
           handoff_pulse,
    output ready
  );
endinterface

interface brmc_out_if #(
  parameter int unsigned SAMPLE_BITS = brmc_pkg::SAMPLE_BITS_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic [brmc_pkg::REGION_BITS-1:0]    region_state;
  logic [brmc_pkg::CNT_BITS-1:0]       packets_emitted;
  logic [brmc_pkg::CNT_BITS-1:0]       entry_rejects;
  logic [brmc_pkg::CNT_BITS-1:0]       persist_peak;
  logic [brmc_pkg::CNT_BITS-1:0]       packet_remaining;
  logic [brmc_pkg::CNT_BITS-1:0]       coast_ticks;
  logic [brmc_pkg::CNT_BITS-1:0]       run_ticks;
  logic [SAMPLE_BITS-1:0]              entry_vout;
  logic [brmc_pkg::TICK_BITS-1:0]      tick_total;

  modport source (
    output valid, region_state, packets_emitted, entry_rejects, persist_peak,
           packet_remaining, coast_ticks, run_ticks, entry_vout, tick_total,
    input  ready
  );
  modport sink (
    input  valid, region_state, packets_emitted, entry_rejects, persist_peak,
           packet_remaining, coast_ticks, run_ticks, entry_vout, tick_total,
    output ready
  );
endinterface

interface brmc_cfg_if ();
  logic                                 valid;
  logic                                 ready;
  logic [brmc_pkg::CFG_IDX_BITS-1:0]    index;
  logic [brmc_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/brmc_fsm.sv]
// Region state machine and diagnostics counters, one update per fired tick.
`default_nettype none

module brmc_fsm #(
  parameter int unsigned SAMPLE_BITS = brmc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FREQ_BITS   = brmc_pkg::FREQ_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire brmc_pkg::brmc_step_t             step_i,
  input  wire logic [SAMPLE_BITS-1:0]           vout_i,
  input  wire logic [FREQ_BITS-1:0]             freq_i,
  input  wire logic [SAMPLE_BITS-1:0]           vref_i,
  input  wire logic [FREQ_BITS-1:0]             freq_ceil_i,
  input  wire logic [SAMPLE_BITS-1:0]           entry_hyst_i,
  input  wire logic [SAMPLE_BITS-1:0]           exit_hyst_i,
  input  wire logic [brmc_pkg::CNT_BITS-1:0]    persist_cnt_i,
  input  wire logic [brmc_pkg::CNT_BITS-1:0]    dwell_i,
  input  wire logic [brmc_pkg::CNT_BITS-1:0]    return_cnt_i,
  input  wire logic [brmc_pkg::CNT_BITS-1:0]    packet_len_i,
  output logic [brmc_pkg::REGION_BITS-1:0]      region_o,
  output logic [brmc_pkg::CNT_BITS-1:0]         emitted_o,
  output logic [brmc_pkg::CNT_BITS-1:0]         rejects_o,
  output logic [brmc_pkg::CNT_BITS-1:0]         peak_o,
  output logic [brmc_pkg::CNT_BITS-1:0]         packet_o,
  output logic [brmc_pkg::CNT_BITS-1:0]         coast_o,
  output logic [brmc_pkg::CNT_BITS-1:0]         run_o,
  output logic [SAMPLE_BITS-1:0]                captured_o,
  output logic [brmc_pkg::TICK_BITS-1:0]        tick_o
);
  import brmc_pkg::*;

  mode_e                  mode_q, mode_d;
  logic [CNT_BITS-1:0]    persist_q, persist_d;
  logic [CNT_BITS-1:0]    return_q, return_d;
  logic [CNT_BITS-1:0]    run_q, run_d;
  logic [CNT_BITS-1:0]    coast_q, coast_d;
  logic [CNT_BITS-1:0]    packet_q, packet_d;
  logic [CNT_BITS-1:0]    emitted_q, emitted_d;
  logic [CNT_BITS-1:0]    reject_q, reject_d;
  logic [CNT_BITS-1:0]    peak_q, peak_d;
  logic [SAMPLE_BITS-1:0] captured_q, captured_d;
  logic [TICK_BITS-1:0]   tick_q, tick_d;
  logic                   handoff_q, handoff_d;

  logic [CNT_BITS-1:0]    hi_thr, lo_thr, vout_ext;
  logic                   at_ceiling, above_hi, below_lo, handoff_set;
  logic [CNT_BITS-1:0]    run_next, persist_next, return_next, packet_dec;

  // Thresholds wrap at the counter width.
  assign hi_thr     = CNT_BITS'(vref_i) + CNT_BITS'(entry_hyst_i);
  assign lo_thr     = CNT_BITS'(vref_i) - CNT_BITS'(exit_hyst_i);
  assign vout_ext   = CNT_BITS'(vout_i);
  assign at_ceiling = (freq_i >= freq_ceil_i);
  assign above_hi   = (vout_ext > hi_thr);
  assign below_lo   = (vout_ext < lo_thr);

  assign handoff_set  = handoff_q | step_i.handoff;
  assign run_next     = run_q + 1'b1;
  assign persist_next = persist_q + 1'b1;
  assign return_next  = return_q + 1'b1;
  assign packet_dec   = (packet_q != '0) ? packet_q - 1'b1 : packet_q;

  always_comb begin
    mode_d     = mode_q;
    persist_d  = persist_q;
    return_d   = return_q;
    run_d      = run_q;
    coast_d    = coast_q;
    packet_d   = packet_q;
    emitted_d  = emitted_q;
    reject_d   = reject_q;
    peak_d     = peak_q;
    captured_d = captured_q;
    tick_d     = tick_q;
    handoff_d  = handoff_q;
    if (step_i.fire) begin
      handoff_d = handoff_set;
      tick_d    = tick_q + 1'b1;
      if (step_i.fault) begin
        mode_d    = MODE_FAULT;
        persist_d = '0;
        return_d  = '0;
      end else if (!step_i.enable) begin
        mode_d = MODE_IDLE;
      end else begin
        unique case (mode_q)
          MODE_RUN: begin
            run_d = run_next;
            if (handoff_set) begin
              // One-shot handoff check: consume the latch either way.
              handoff_d = 1'b0;
              if (at_ceiling && above_hi && step_i.rising) begin
                mode_d = MODE_PREP;
              end else begin
                run_d     = '0;
                persist_d = '0;
              end
            end else if (at_ceiling && above_hi) begin
              if (run_next < dwell_i) begin
                reject_d  = reject_q + 1'b1;
                persist_d = '0;
              end else begin
                persist_d = persist_next;
                if (persist_next > peak_q) begin
                  peak_d = persist_next;
                end
                if (persist_next >= persist_cnt_i) begin
                  captured_d = vout_i;
                  mode_d     = MODE_PREP;
                  persist_d  = '0;
                  peak_d     = '0;
                end
              end
            end else begin
              persist_d = '0;
              peak_d    = '0;
              reject_d  = reject_q + 1'b1;
            end
          end
          MODE_PREP: begin
            mode_d   = MODE_ON;
            packet_d = packet_len_i;
          end
          MODE_ON: begin
            packet_d = packet_dec;
            if (packet_dec == '0) begin
              emitted_d = emitted_q + 1'b1;
              mode_d    = MODE_OFF;
              coast_d   = '0;
            end
          end
          MODE_OFF: begin
            coast_d = coast_q + 1'b1;
            if (below_lo) begin
              packet_d = packet_len_i;
              mode_d   = MODE_ON;
            end else if (!at_ceiling) begin
              return_d = return_next;
              if (return_next >= return_cnt_i) begin
                mode_d    = MODE_RUN;
                run_d     = '0;
                persist_d = '0;
                return_d  = '0;
              end
            end else begin
              return_d = '0;
            end
          end
          default: begin
            // Idle, fault and any stray code enter continuous run.
            mode_d    = MODE_RUN;
            run_d     = '0;
            persist_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      persist_q  <= '0;
      return_q   <= '0;
      run_q      <= '0;
      coast_q    <= '0;
      packet_q   <= '0;
      emitted_q  <= '0;
      reject_q   <= '0;
      peak_q     <= '0;
      captured_q <= '0;
      tick_q     <= '0;
      handoff_q  <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      persist_q  <= persist_d;
      return_q   <= return_d;
      run_q      <= run_d;
      coast_q    <= coast_d;
      packet_q   <= packet_d;
      emitted_q  <= emitted_d;
      reject_q   <= reject_d;
      peak_q     <= peak_d;
      captured_q <= captured_d;
      tick_q     <= tick_d;
      handoff_q  <= handoff_d;
    end
  end

  // Results are the values after this tick's update.
  assign region_o   = region_code(mode_d);
  assign emitted_o  = emitted_d;
  assign rejects_o  = reject_d;
  assign peak_o     = peak_d;
  assign packet_o   = packet_d;
  assign coast_o    = coast_d;
  assign run_o      = run_d;
  assign captured_o = captured_d;
  assign tick_o     = tick_d;

  a_fault_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.fire && step_i.fault |=> mode_q == MODE_FAULT && persist_q == '0)
    else $error("fault tick did not force fault mode");

  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.fire |=> tick_q == $past(tick_q) + 1'b1)
    else $error("tick counter did not advance on a fired tick");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i.fire |=> $stable(mode_q) && $stable(tick_q) && $stable(handoff_q))
    else $error("state changed without a fired tick");

  a_prep_to_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.fire && step_i.enable && !step_i.fault && mode_q == MODE_PREP
    |=> mode_q == MODE_ON && packet_q == $past(packet_len_i))
    else $error("burst prep did not start a packet");

endmodule

`default_nettype wire

[rtl/core/burst_region_mode_controller.sv]
// Top level of the burst region mode controller: channels, registers, pipeline.
`default_nettype none

// Channel   Dir  Role      Payload
// in_req    in   request   vout_sample, vout_rising, freq_command, run_enable,
//                          fault_active, handoff_pulse
// out_res   out  result    region_state and diagnostics counters, tick_total
// cfg_req   in   write     index (register 0..7), data
//
// Cycles: one request per clock sustained while out_res.ready stays high; a result
//   leaves through the input register and then the result register.
// Reset: registers take their default values, the state machine goes idle and
//   every counter clears.
// Stalls: the result register holds while out_res.ready is low; the input
//   register keeps taking a request as long as it drains into the result
//   register in the same cycle, so ready drops only with both stages full.
// Config writes are taken in every cycle (cfg_req.ready is always high).

module burst_region_mode_controller #(
  parameter int unsigned SAMPLE_BITS = brmc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FREQ_BITS   = brmc_pkg::FREQ_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  brmc_in_if.sink      in_req,
  brmc_out_if.source   out_res,
  brmc_cfg_if.sink     cfg_req
);
  import brmc_pkg::*;

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] vref_q;
  logic [FREQ_BITS-1:0]   freq_ceil_q;
  logic [SAMPLE_BITS-1:0] entry_hyst_q;
  logic [SAMPLE_BITS-1:0] exit_hyst_q;
  logic [CNT_BITS-1:0]    persist_cnt_q;
  logic [CNT_BITS-1:0]    dwell_q;
  logic [CNT_BITS-1:0]    return_cnt_q;
  logic [CNT_BITS-1:0]    packet_len_q;

  // Input register.
  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] in_vout_q;
  logic                   in_rising_q;
  logic [FREQ_BITS-1:0]   in_freq_q;
  logic                   in_enable_q;
  logic                   in_fault_q;
  logic                   in_handoff_q;

  // Result register.
  logic                   out_valid_q;
  logic [REGION_BITS-1:0] out_region_q;
  logic [CNT_BITS-1:0]    out_emitted_q;
  logic [CNT_BITS-1:0]    out_rejects_q;
  logic [CNT_BITS-1:0]    out_peak_q;
  logic [CNT_BITS-1:0]    out_packet_q;
  logic [CNT_BITS-1:0]    out_coast_q;
  logic [CNT_BITS-1:0]    out_run_q;
  logic [SAMPLE_BITS-1:0] out_captured_q;
  logic [TICK_BITS-1:0]   out_tick_q;

  logic                   in_take, out_load, fire, cfg_take;
  brmc_step_t             step;

  logic [REGION_BITS-1:0] res_region;
  logic [CNT_BITS-1:0]    res_emitted, res_rejects, res_peak, res_packet;
  logic [CNT_BITS-1:0]    res_coast, res_run;
  logic [SAMPLE_BITS-1:0] res_captured;
  logic [TICK_BITS-1:0]   res_tick;

  // Advance the input stage whenever the result register is free or draining.
  assign out_load     = !out_valid_q || out_res.ready;
  assign fire         = in_valid_q && out_load;
  assign in_req.ready = !in_valid_q || out_load;
  assign in_take      = in_req.valid && in_req.ready;
  assign cfg_req.ready = 1'b1;
  assign cfg_take     = cfg_req.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q        <= SAMPLE_BITS'(VREF_RESET);
      freq_ceil_q   <= FREQ_BITS'(FREQ_CEIL_RESET);
      entry_hyst_q  <= SAMPLE_BITS'(ENTRY_HYST_RESET);
      exit_hyst_q   <= SAMPLE_BITS'(EXIT_HYST_RESET);
      persist_cnt_q <= CNT_BITS'(PERSIST_RESET);
      dwell_q       <= CNT_BITS'(DWELL_RESET);
      return_cnt_q  <= CNT_BITS'(RETURN_RESET);
      packet_len_q  <= CNT_BITS'(PACKET_RESET);
    end else if (cfg_take) begin
      unique case (cfg_idx_e'(cfg_req.index))
        CFG_VREF:       vref_q        <= cfg_req.data[SAMPLE_BITS-1:0];
        CFG_FREQ_CEIL:  freq_ceil_q   <= cfg_req.data[FREQ_BITS-1:0];
        CFG_ENTRY_HYST: entry_hyst_q  <= cfg_req.data[SAMPLE_BITS-1:0];
        CFG_EXIT_HYST:  exit_hyst_q   <= cfg_req.data[SAMPLE_BITS-1:0];
        CFG_PERSIST:    persist_cnt_q <= cfg_req.data[CNT_BITS-1:0];
        CFG_DWELL:      dwell_q       <= cfg_req.data[CNT_BITS-1:0];
        CFG_RETURN:     return_cnt_q  <= cfg_req.data[CNT_BITS-1:0];
        CFG_PACKET:     packet_len_q  <= cfg_req.data[CNT_BITS-1:0];
      endcase
    end
  end

  // Input stage: capture a request, drop the valid once it fires.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_vout_q    <= in_req.vout_sample;
      in_rising_q  <= in_req.vout_rising;
      in_freq_q    <= in_req.freq_command;
      in_enable_q  <= in_req.run_enable;
      in_fault_q   <= in_req.fault_active;
      in_handoff_q <= in_req.handoff_pulse;
    end
  end

  always_comb begin
    step.fire    = fire;
    step.rising  = in_rising_q;
    step.enable  = in_enable_q;
    step.fault   = in_fault_q;
    step.handoff = in_handoff_q;
  end

  brmc_fsm #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FREQ_BITS   (FREQ_BITS)
  ) u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .vout_i        (in_vout_q),
    .freq_i        (in_freq_q),
    .vref_i        (vref_q),
    .freq_ceil_i   (freq_ceil_q),
    .entry_hyst_i  (entry_hyst_q),
    .exit_hyst_i   (exit_hyst_q),
    .persist_cnt_i (persist_cnt_q),
    .dwell_i       (dwell_q),
    .return_cnt_i  (return_cnt_q),
    .packet_len_i  (packet_len_q),
    .region_o      (res_region),
    .emitted_o     (res_emitted),
    .rejects_o     (res_rejects),
    .peak_o        (res_peak),
    .packet_o      (res_packet),
    .coast_o       (res_coast),
    .run_o         (res_run),
    .captured_o    (res_captured),
    .tick_o        (res_tick)
  );

  // Result stage: load on a fired tick, hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_region_q   <= res_region;
      out_emitted_q  <= res_emitted;
      out_rejects_q  <= res_rejects;
      out_peak_q     <= res_peak;
      out_packet_q   <= res_packet;
      out_coast_q    <= res_coast;
      out_run_q      <= res_run;
      out_captured_q <= res_captured;
      out_tick_q     <= res_tick;
    end
  end

  assign out_res.valid            = out_valid_q;
  assign out_res.region_state     = out_region_q;
  assign out_res.packets_emitted  = out_emitted_q;
  assign out_res.entry_rejects    = out_rejects_q;
  assign out_res.persist_peak     = out_peak_q;
  assign out_res.packet_remaining = out_packet_q;
  assign out_res.coast_ticks      = out_coast_q;
  assign out_res.run_ticks        = out_run_q;
  assign out_res.entry_vout       = out_captured_q;
  assign out_res.tick_total       = out_tick_q;

  a_no_fire_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> in_valid_q)
    else $error("tick fired with an empty input register");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res.ready |=> out_valid_q && $stable(out_tick_q))
    else $error("stalled result changed");

  a_ready_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_req.ready |-> in_valid_q && out_valid_q && !out_res.ready)
    else $error("request blocked without a full pipeline");

endmodule

`default_nettype wire
